>>> rtl/ast_pkg.sv
// ----------------------------------------------------------------------------
// ast_pkg: shared types and constants of the assembly source tokenizer
// Token kinds, lexer modes, the character class record and the token record.
// ----------------------------------------------------------------------------
package ast_pkg;

	localparam logic [2:0] KIND_NAME = 3'd0;
	localparam logic [2:0] KIND_INT  = 3'd1;
	localparam logic [2:0] KIND_REG  = 3'd2;
	localparam logic [2:0] KIND_CHAR = 3'd3;
	localparam logic [2:0] KIND_EOF  = 3'd4;

	localparam logic [7:0] CH_UNDER = 8'h5F;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_DOT   = 8'h2E;

	localparam logic [4:0] BASE_2  = 5'd2;
	localparam logic [4:0] BASE_8  = 5'd8;
	localparam logic [4:0] BASE_10 = 5'd10;
	localparam logic [4:0] BASE_16 = 5'd16;

	typedef enum logic [2:0] {
		S_IDLE,
		S_COMMENT,
		S_NAME,
		S_REG,
		S_ZERO,
		S_NUM,
		S_SKIP
	} scan_mode_t;

	// Classification of one source byte, worked out in the front end.
	typedef struct packed {
		logic       is_space;
		logic       name_lead;
		logic       is_dec;
		logic       is_digit;
		logic [3:0] digit;
		logic       is_hex_mark;
		logic       is_bin_mark;
		logic       is_semi;
		logic       is_pct;
		logic       is_nl;
		logic       is_under;
		logic       is_zero;
	} char_class_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  punct;
		logic [15:0] line;
		logic [15:0] column;
		logic [15:0] length;
		logic [63:0] value;
		logic        digit_err;
		logic        ovf_err;
		logic        last;
	} token_t;

endpackage

>>> rtl/assembly_source_tokenizer.sv
// ----------------------------------------------------------------------------
// assembly_source_tokenizer: streaming lexer for assembly source text
// Turns a byte stream into name, integer, register, character and EOF tokens.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+-------------------------------
//  input    | in        | in_valid / in_ready   | char_code, end_of_text
//  output   | out       | out_valid / out_ready | token_kind ... last_of_run
//
// One byte is accepted per cycle while the front queue has room. A byte that
// yields two tokens holds the lexer while the second token goes out, so the
// lexer takes no new byte until that token has left.
// Each token is registered in the output queue before it reaches the port.
// Reset clears the lexer state, the position counters and both queues.
// Either side may stall at any time; the two-beat queues absorb it.
//
// The front end classifies each byte and stamps it with line and column; a
// two-entry queue decouples it from the back end, which runs the lexer state
// machine. A second two-entry queue holds finished tokens for the consumer.
// Integer digits are folded in as shift-and-add with an overflow check on the
// top bits of the widened product.
module assembly_source_tokenizer #(
	parameter int POSITION_BITS = 16,
	parameter int VALUE_BITS    = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  char_code,
	input  logic        end_of_text,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  token_kind,
	output logic [7:0]  punct_code,
	output logic [15:0] start_line,
	output logic [15:0] start_column,
	output logic [15:0] token_length,
	output logic [63:0] int_value,
	output logic        digit_range_error,
	output logic        overflow_error,
	output logic        last_of_run
);
	localparam int CLS_BITS = $bits(ast_pkg::char_class_t);
	localparam int MID_BITS = CLS_BITS + 9 + 2 * POSITION_BITS;
	localparam int TOK_BITS = $bits(ast_pkg::token_t);

	ast_pkg::char_class_t     f_cls, b_cls;
	logic [POSITION_BITS-1:0] f_line, f_col, b_line, b_col;
	logic [MID_BITS-1:0]      mid_in, mid_out;
	logic                     mid_valid, mid_ready;
	logic [7:0]               b_char;
	logic                     b_eot;
	logic                     tok_valid, tok_ready;
	ast_pkg::token_t          tok, out_tok;
	logic [TOK_BITS-1:0]      out_bits;

	ast_front #(.POSITION_BITS(POSITION_BITS)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (in_valid && in_ready),
		.char_code  (char_code),
		.end_of_text(end_of_text),
		.cls        (f_cls),
		.line       (f_line),
		.column     (f_col)
	);

	assign mid_in = {f_cls, char_code, end_of_text, f_line, f_col};

	ast_fifo #(.WIDTH(MID_BITS), .DEPTH(2)) u_mid_q (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (mid_in),
		.out_valid(mid_valid),
		.out_ready(mid_ready),
		.out_data (mid_out)
	);

	assign {b_cls, b_char, b_eot, b_line, b_col} = mid_out;

	ast_back #(.POSITION_BITS(POSITION_BITS), .VALUE_BITS(VALUE_BITS)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (mid_valid),
		.in_ready   (mid_ready),
		.cls        (b_cls),
		.char_code  (b_char),
		.end_of_text(b_eot),
		.line       (b_line),
		.column     (b_col),
		.tok_valid  (tok_valid),
		.tok_ready  (tok_ready),
		.tok        (tok)
	);

	ast_fifo #(.WIDTH(TOK_BITS), .DEPTH(2)) u_out_q (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (tok_valid),
		.in_ready (tok_ready),
		.in_data  (tok),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_bits)
	);

	assign out_tok           = out_bits;
	assign token_kind        = out_tok.kind;
	assign punct_code        = out_tok.punct;
	assign start_line        = out_tok.line;
	assign start_column      = out_tok.column;
	assign token_length      = out_tok.length;
	assign int_value         = out_tok.value;
	assign digit_range_error = out_tok.digit_err;
	assign overflow_error    = out_tok.ovf_err;
	assign last_of_run       = out_tok.last;
endmodule

>>> rtl/ast_fifo.sv
// ----------------------------------------------------------------------------
// ast_fifo: small register queue with valid/ready on both sides
// Used between the front and back ends and as the result buffer.
// ----------------------------------------------------------------------------
module ast_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [WIDTH-1:0] in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [WIDTH-1:0] out_data
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             push, pop;

	assign in_ready  = (count_q != CW'(DEPTH));
	assign out_valid = (count_q != '0);
	assign out_data  = mem_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end
endmodule

>>> rtl/ast_front.sv
// ----------------------------------------------------------------------------
// ast_front: character classifier and position tracker
// Tags each accepted byte with its class and its line and column.
// ----------------------------------------------------------------------------
module ast_front #(
	parameter int POSITION_BITS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     accept,
	input  logic [7:0]               char_code,
	input  logic                     end_of_text,
	output ast_pkg::char_class_t     cls,
	output logic [POSITION_BITS-1:0] line,
	output logic [POSITION_BITS-1:0] column
);
	localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

	logic [POSITION_BITS-1:0] line_q, col_q;
	logic                     alpha, lo_hex, up_hex;

	always_comb begin
		alpha  = (char_code >= 8'h61 && char_code <= 8'h7A) ||
		         (char_code >= 8'h41 && char_code <= 8'h5A);
		lo_hex = (char_code >= 8'h61 && char_code <= 8'h66);
		up_hex = (char_code >= 8'h41 && char_code <= 8'h46);
		cls.is_space      = (char_code == 8'h20) || (char_code >= 8'h09 && char_code <= 8'h0D);
		cls.name_lead     = alpha || (char_code == ast_pkg::CH_UNDER) ||
		                    (char_code == ast_pkg::CH_DOT);
		cls.is_dec        = (char_code >= 8'h30 && char_code <= 8'h39);
		cls.is_digit      = cls.is_dec || lo_hex || up_hex;
		if (cls.is_dec) begin
			cls.digit = 4'(char_code - 8'h30);
		end else if (lo_hex) begin
			cls.digit = 4'(char_code - 8'h57);
		end else if (up_hex) begin
			cls.digit = 4'(char_code - 8'h37);
		end else begin
			cls.digit = 4'd0;
		end
		cls.is_hex_mark = (char_code == 8'h78) || (char_code == 8'h58);
		cls.is_bin_mark = (char_code == 8'h62) || (char_code == 8'h42);
		cls.is_semi     = (char_code == ast_pkg::CH_SEMI);
		cls.is_pct      = (char_code == ast_pkg::CH_PCT);
		cls.is_nl       = (char_code == ast_pkg::CH_NL);
		cls.is_under    = (char_code == ast_pkg::CH_UNDER);
		cls.is_zero     = (char_code == ast_pkg::CH_ZERO);
	end

	assign line   = line_q;
	assign column = (col_q == POS_MAX) ? POS_MAX : col_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_q <= POSITION_BITS'(1);
			col_q  <= '0;
		end else if (accept && !end_of_text) begin
			if (cls.is_nl) begin
				line_q <= (line_q == POS_MAX) ? POS_MAX : line_q + 1'b1;
				col_q  <= '0;
			end else begin
				col_q <= column;
			end
		end
	end
endmodule

>>> rtl/ast_back.sv
// ----------------------------------------------------------------------------
// ast_back: lexer state machine
// Consumes classified bytes and produces up to two tokens per byte.
// ----------------------------------------------------------------------------
module ast_back #(
	parameter int POSITION_BITS = 16,
	parameter int VALUE_BITS    = 64
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  ast_pkg::char_class_t     cls,
	input  logic [7:0]               char_code,
	input  logic                     end_of_text,
	input  logic [POSITION_BITS-1:0] line,
	input  logic [POSITION_BITS-1:0] column,
	output logic                     tok_valid,
	input  logic                     tok_ready,
	output ast_pkg::token_t          tok
);
	localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

	ast_pkg::scan_mode_t      mode_q, mode_d;
	logic [4:0]               base_q, base_d;
	logic [VALUE_BITS-1:0]    acc_q, acc_d;
	logic [POSITION_BITS-1:0] sl_q, sl_d, sc_q, sc_d, cnt_q, cnt_d;
	logic [1:0]               err_q, err_d;
	logic                     pend_q;
	ast_pkg::token_t          pend_tok_q;

	ast_pkg::token_t          t0, t1, flush_tok;
	logic [1:0]               ntok;
	logic                     go, flush_any, take;
	logic [3:0]               dig;
	logic [VALUE_BITS+3:0]    prod;

	always_comb begin
		mode_d = mode_q;
		base_d = base_q;
		acc_d  = acc_q;
		sl_d   = sl_q;
		sc_d   = sc_q;
		cnt_d  = cnt_q;
		err_d  = err_q;
		t0     = '0;
		t1     = '0;
		ntok   = 2'd0;
		go     = 1'b1;
		dig    = cls.digit;
		prod   = '0;

		// Pending token as it stands on entry. The skip-mode flush, which can follow an
		// overflow in the same byte, takes a zero value and the updated error flags.
		flush_tok        = '0;
		flush_any        = 1'b1;
		flush_tok.line   = 16'(sl_q);
		flush_tok.column = 16'(sc_q);
		flush_tok.length = 16'(cnt_q);
		case (mode_q)
			ast_pkg::S_NAME: flush_tok.kind = ast_pkg::KIND_NAME;
			ast_pkg::S_REG:  flush_tok.kind = ast_pkg::KIND_REG;
			ast_pkg::S_ZERO, ast_pkg::S_NUM, ast_pkg::S_SKIP: begin
				flush_tok.kind      = ast_pkg::KIND_INT;
				flush_tok.value     = 64'(acc_q);
				flush_tok.digit_err = err_q[0];
				flush_tok.ovf_err   = err_q[1];
			end
			default: flush_any = 1'b0;
		endcase

		if (end_of_text) begin
			if (flush_any) begin
				t0   = flush_tok;
				ntok = 2'd1;
			end
			mode_d = ast_pkg::S_IDLE;
			acc_d  = '0;
			base_d = ast_pkg::BASE_10;
			err_d  = '0;
			if (flush_any) begin
				t1.kind   = ast_pkg::KIND_EOF;
				t1.line   = 16'(line);
				t1.column = 16'(column);
				ntok      = 2'd2;
			end else begin
				t0.kind   = ast_pkg::KIND_EOF;
				t0.line   = 16'(line);
				t0.column = 16'(column);
				ntok      = 2'd1;
			end
		end else begin
			if (mode_d == ast_pkg::S_COMMENT) begin
				if (cls.is_nl) begin
					mode_d = ast_pkg::S_IDLE;
				end
				go = 1'b0;
			end
			if (go && mode_d == ast_pkg::S_ZERO) begin
				if (cls.is_hex_mark || cls.is_bin_mark) begin
					base_d = cls.is_hex_mark ? ast_pkg::BASE_16 : ast_pkg::BASE_2;
					mode_d = ast_pkg::S_NUM;
					cnt_d  = (cnt_d == POS_MAX) ? POS_MAX : cnt_d + 1'b1;
					go     = 1'b0;
				end else begin
					base_d = ast_pkg::BASE_8;
					mode_d = ast_pkg::S_NUM;
				end
			end
			if (go && mode_d == ast_pkg::S_NUM) begin
				if (cls.is_under) begin
					cnt_d = (cnt_d == POS_MAX) ? POS_MAX : cnt_d + 1'b1;
					go    = 1'b0;
				end else if (!cls.is_digit) begin
					t0     = flush_tok;
					ntok   = 2'd1;
					mode_d = ast_pkg::S_IDLE;
				end else begin
					if (5'(dig) >= base_d) begin
						err_d[0] = 1'b1;
						dig      = 4'd0;
					end
					// Base times value as shifts, with one add for base ten.
					case (base_d)
						ast_pkg::BASE_2:  prod = {3'b0, acc_d, 1'b0};
						ast_pkg::BASE_8:  prod = {1'b0, acc_d, 3'b0};
						ast_pkg::BASE_16: prod = {acc_d, 4'b0};
						default:          prod = {1'b0, acc_d, 3'b0} + {3'b0, acc_d, 1'b0};
					endcase
					prod = prod + (VALUE_BITS + 4)'(dig);
					if (prod[VALUE_BITS+3:VALUE_BITS] != 4'd0) begin
						err_d[1] = 1'b1;
						acc_d    = '0;
						mode_d   = ast_pkg::S_SKIP;
					end else begin
						acc_d = prod[VALUE_BITS-1:0];
						cnt_d = (cnt_d == POS_MAX) ? POS_MAX : cnt_d + 1'b1;
						go    = 1'b0;
					end
				end
			end
			if (go && mode_d == ast_pkg::S_SKIP) begin
				if (cls.is_dec) begin
					cnt_d = (cnt_d == POS_MAX) ? POS_MAX : cnt_d + 1'b1;
					go    = 1'b0;
				end else begin
					t0           = flush_tok;
					t0.value     = '0;
					t0.digit_err = err_d[0];
					t0.ovf_err   = err_d[1];
					ntok         = 2'd1;
					mode_d       = ast_pkg::S_IDLE;
				end
			end
			if (go && (mode_d == ast_pkg::S_NAME || mode_d == ast_pkg::S_REG)) begin
				if (cls.name_lead || cls.is_dec) begin
					cnt_d = (cnt_d == POS_MAX) ? POS_MAX : cnt_d + 1'b1;
					go    = 1'b0;
				end else begin
					t0     = flush_tok;
					ntok   = 2'd1;
					mode_d = ast_pkg::S_IDLE;
				end
			end
			if (go) begin
				if (mode_q != ast_pkg::S_IDLE) begin
					acc_d  = '0;
					base_d = ast_pkg::BASE_10;
					err_d  = '0;
				end
				mode_d = ast_pkg::S_IDLE;
				if (cls.is_space) begin
					mode_d = ast_pkg::S_IDLE;
				end else if (cls.is_semi) begin
					mode_d = ast_pkg::S_COMMENT;
				end else if (cls.name_lead || cls.is_pct || cls.is_dec) begin
					if (cls.name_lead) begin
						mode_d = ast_pkg::S_NAME;
					end else if (cls.is_pct) begin
						mode_d = ast_pkg::S_REG;
					end else if (cls.is_zero) begin
						mode_d = ast_pkg::S_ZERO;
					end else begin
						mode_d = ast_pkg::S_NUM;
					end
					sl_d   = line;
					sc_d   = column;
					cnt_d  = POSITION_BITS'(1);
					base_d = ast_pkg::BASE_10;
					err_d  = '0;
					acc_d  = cls.is_dec ? VALUE_BITS'(cls.digit) : '0;
				end else begin
					if (ntok == 2'd0) begin
						t0.kind   = ast_pkg::KIND_CHAR;
						t0.punct  = char_code;
						t0.line   = 16'(line);
						t0.column = 16'(column);
						t0.length = 16'd1;
						ntok      = 2'd1;
					end else begin
						t1.kind   = ast_pkg::KIND_CHAR;
						t1.punct  = char_code;
						t1.line   = 16'(line);
						t1.column = 16'(column);
						t1.length = 16'd1;
						ntok      = 2'd2;
					end
				end
			end
		end
		if (ntok == 2'd1) begin
			t0.last = 1'b1;
		end else if (ntok == 2'd2) begin
			t1.last = 1'b1;
		end
	end

	// A byte is taken when no second token waits and the result side has room.
	assign in_ready  = !pend_q && tok_ready;
	assign take      = in_valid && in_ready;
	assign tok_valid = pend_q || (take && ntok != 2'd0);
	assign tok       = pend_q ? pend_tok_q : t0;

	always_ff @(posedge clk) begin
		if (take && ntok == 2'd2) begin
			pend_tok_q <= t1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= ast_pkg::S_IDLE;
			err_q  <= '0;
			pend_q <= 1'b0;
			base_q <= ast_pkg::BASE_10;
			acc_q  <= '0;
			sl_q   <= '0;
			sc_q   <= '0;
			cnt_q  <= '0;
		end else begin
			if (take) begin
				mode_q <= mode_d;
				err_q  <= err_d;
				base_q <= base_d;
				acc_q  <= acc_d;
				sl_q   <= sl_d;
				sc_q   <= sc_d;
				cnt_q  <= cnt_d;
			end
			if (pend_q && tok_ready) begin
				pend_q <= 1'b0;
			end else if (take && ntok == 2'd2) begin
				pend_q <= 1'b1;
			end
		end
	end
endmodule

>>> rtl/ast_checker.sv
// ----------------------------------------------------------------------------
// ast_checker: port-level checks for the assembly source tokenizer
// Watches the result channel and is bound to the top level.
// ----------------------------------------------------------------------------
module ast_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  token_kind,
	input logic [15:0] token_length,
	input logic [63:0] int_value,
	input logic        digit_range_error,
	input logic        overflow_error,
	input logic        last_of_run
);
	// A stalled result beat stays offered.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result beat dropped while stalled");

	// EOF has no length and always closes its run.
	a_eof: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && token_kind == ast_pkg::KIND_EOF |-> token_length == 16'd0 && last_of_run)
		else $error("malformed EOF token");

	// Only integers carry a value or error flags.
	a_nonint: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && token_kind != ast_pkg::KIND_INT |->
		int_value == 64'd0 && !digit_range_error && !overflow_error)
		else $error("value or error on a non-integer token");

	// An overflowed literal reads as zero.
	a_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && overflow_error |-> int_value == 64'd0)
		else $error("overflowed literal with nonzero value");

	// A single-character token is one long and ends its run.
	a_char: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && token_kind == ast_pkg::KIND_CHAR |-> token_length == 16'd1 && last_of_run)
		else $error("malformed single-character token");
endmodule

bind assembly_source_tokenizer ast_checker u_ast_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.out_valid        (out_valid),
	.out_ready        (out_ready),
	.token_kind       (token_kind),
	.token_length     (token_length),
	.int_value        (int_value),
	.digit_range_error(digit_range_error),
	.overflow_error   (overflow_error),
	.last_of_run      (last_of_run)
);
